### design/siq_pkg.sv
// ----------------------------------------------------------------------------
// siq_pkg: shared types for the sorted-insert priority queue
// Entry fields, status codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package siq_pkg;

	typedef logic [31:0] key_t;
	typedef logic [15:0] tag_t;
	typedef logic [4:0]  count_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic ins_ok;
		logic rem_ok;
		logic sorted;
		logic occ;
		logic at_tail;
	} cell_ctl_t;

endpackage

### design/siq_if.sv
// ----------------------------------------------------------------------------
// siq_if: request and response channels of the priority queue
// Valid/ready handshake; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface siq_req_if;
	import siq_pkg::*;

	logic valid;
	logic ready;
	logic op;
	key_t key;
	tag_t tag;

	modport source (output valid, output op, output key, output tag, input ready);
	modport sink   (input valid, input op, input key, input tag, output ready);
endinterface

interface siq_rsp_if;
	import siq_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	key_t    out_key;
	tag_t    out_tag;
	count_t  count;
	logic    is_empty;

	modport source (output valid, output status, output out_key, output out_tag,
		output count, output is_empty, input ready);
	modport sink   (input valid, input status, input out_key, input out_tag,
		input count, input is_empty, output ready);
endinterface

### design/siq_cell.sv
// ----------------------------------------------------------------------------
// siq_cell: one slot of the queue
// Holds one entry; compares against the insert key and loads from the new
// entry, its left neighbour or its right neighbour.
// ----------------------------------------------------------------------------
module siq_cell (
	input  logic              clk,
	input  siq_pkg::cell_ctl_t ctl,
	input  siq_pkg::key_t     new_key,
	input  siq_pkg::tag_t     new_tag,
	input  siq_pkg::key_t     left_key,
	input  siq_pkg::tag_t     left_tag,
	input  siq_pkg::key_t     right_key,
	input  siq_pkg::tag_t     right_tag,
	input  logic              hit_in,
	output logic              hit_out,
	output siq_pkg::key_t     key_q,
	output siq_pkg::tag_t     tag_q
);
	import siq_pkg::*;

	logic ge;

	// first occupied slot whose key is >= the new key (sorted mode only), or the tail slot
	assign ge      = ctl.sorted && ctl.occ && (new_key <= key_q);
	assign hit_out = hit_in || ge || ctl.at_tail;

	always_ff @(posedge clk) begin
		if (ctl.rem_ok) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (ctl.ins_ok && hit_out && !hit_in) begin
			key_q <= new_key;
			tag_q <= new_tag;
		end else if (ctl.ins_ok && hit_in) begin
			key_q <= left_key;
			tag_q <= left_tag;
		end
	end

endmodule

### design/sorted_insert_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue: bounded priority queue on a chain of cells
// The response is registered and becomes valid in the cycle after the request transaction.
// Throughput: one operation per cycle while no response is held or rsp.ready is high;
// every cell compares and shifts in parallel, the output register holds one response.
// Reset: fill count cleared, sorted mode set; entry storage is not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	siq_req_if.sink       req,
	siq_rsp_if.source     rsp
);
	import siq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          sorted_q;
	logic          accept;
	logic          is_full;
	logic          is_emp;
	logic          ins_ok;
	logic          rem_ok;
	status_t       status_nxt;

	key_t          cell_key [DEPTH];
	tag_t          cell_tag [DEPTH];
	logic          cell_hit [DEPTH];

	logic          valid_q;
	status_t       status_q;
	key_t          out_key_q;
	tag_t          out_tag_q;
	logic [CW-1:0] count_out_q;

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_emp    = (count_q == '0);
	assign ins_ok    = accept && (req.op == OP_INSERT) && !is_full;
	assign rem_ok    = accept && (req.op == OP_REMOVE) && !is_emp;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		if (req.op == OP_REMOVE) begin
			if (is_emp) status_nxt = ST_EMPTY;
			else        count_nxt  = count_q - CW'(1);
		end else begin
			if (is_full) status_nxt = ST_FULL;
			else         count_nxt  = count_q + CW'(1);
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			cell_ctl_t ctl;
			key_t      lkey;
			tag_t      ltag;
			key_t      rkey;
			tag_t      rtag;
			logic      hin;

			assign ctl.ins_ok  = ins_ok;
			assign ctl.rem_ok  = rem_ok;
			assign ctl.sorted  = sorted_q;
			assign ctl.occ     = (CW'(i) < count_q);
			assign ctl.at_tail = (CW'(i) == count_q);

			if (i == 0) begin : g_head
				assign lkey = '0;
				assign ltag = '0;
				assign hin  = 1'b0;
			end else begin : g_body
				assign lkey = cell_key[i-1];
				assign ltag = cell_tag[i-1];
				assign hin  = cell_hit[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign rkey = cell_key[i];
				assign rtag = cell_tag[i];
			end else begin : g_mid
				assign rkey = cell_key[i+1];
				assign rtag = cell_tag[i+1];
			end

			siq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.new_key   (req.key),
				.new_tag   (req.tag),
				.left_key  (lkey),
				.left_tag  (ltag),
				.right_key (rkey),
				.right_tag (rtag),
				.hit_in    (hin),
				.hit_out   (cell_hit[i]),
				.key_q     (cell_key[i]),
				.tag_q     (cell_tag[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sorted_q <= 1'b1;
			valid_q  <= 1'b0;
		end else begin
			if (cfg_we) sorted_q <= cfg_wdata;
			if (accept) begin
				count_q <= count_nxt;
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			out_key_q   <= rem_ok ? cell_key[0] : '0;
			out_tag_q   <= rem_ok ? cell_tag[0] : '0;
			count_out_q <= count_nxt;
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.status   = status_q;
	assign rsp.out_key  = out_key_q;
	assign rsp.out_tag  = out_tag_q;
	assign rsp.count    = count_t'(count_out_q);
	assign rsp.is_empty = (count_out_q == '0);

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the sorted-insert priority queue
// Sends insert and remove transactions with random gaps and response stalls.
// Expected responses come from a behavioural copy of the queue and are
// compared field by field, in order, by a single checking process.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import siq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int IDLE_PCT   = 37;

	typedef struct {
		status_t status;
		key_t    out_key;
		tag_t    out_tag;
		count_t  count;
		logic    is_empty;
	} q_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	siq_req_if req_ch ();
	siq_rsp_if rsp_ch ();

	sorted_insert_priority_queue #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// behavioural copy of the queue
	key_t      model_keys [DEPTH];
	tag_t      model_tags [DEPTH];
	int        model_fill;
	bit        model_sorted;
	q_result_t pending_results [$];

	int mismatches;
	int idle_cycles;
	bit no_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic q_result_t queue_model_apply(logic op, key_t key, tag_t tag);
		q_result_t r;
		int        pos;
		r.status  = ST_OK;
		r.out_key = '0;
		r.out_tag = '0;
		if (op == OP_REMOVE) begin
			if (model_fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.out_key = model_keys[0];
				r.out_tag = model_tags[0];
				for (int i = 0; i < model_fill - 1; i++) begin
					model_keys[i] = model_keys[i + 1];
					model_tags[i] = model_tags[i + 1];
				end
				model_fill--;
			end
		end else if (model_fill >= DEPTH) begin
			r.status = ST_FULL;
		end else begin
			pos = model_fill;
			if (model_sorted) begin
				for (int i = 0; i < model_fill; i++) begin
					if (key <= model_keys[i]) begin
						pos = i;
						break;
					end
				end
			end
			for (int i = model_fill; i > pos; i--) begin
				model_keys[i] = model_keys[i - 1];
				model_tags[i] = model_tags[i - 1];
			end
			model_keys[pos] = key;
			model_tags[pos] = tag;
			model_fill++;
		end
		r.count    = count_t'(model_fill);
		r.is_empty = (model_fill == 0);
		return r;
	endfunction

	// response check first, then prediction for the request taken at this edge
	always @(posedge clk) begin
		q_result_t exp_r;
		bit        moved;
		moved = 1'b0;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			moved = 1'b1;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response, status %0d key %h tag %h", $time,
					rsp_ch.status, rsp_ch.out_key, rsp_ch.out_tag);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_ch.status !== exp_r.status) begin
					$display("%0t: status expected %0d, actual %0d", $time,
						exp_r.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.out_key !== exp_r.out_key) begin
					$display("%0t: out_key expected %h, actual %h", $time,
						exp_r.out_key, rsp_ch.out_key);
					mismatches++;
				end
				if (rsp_ch.out_tag !== exp_r.out_tag) begin
					$display("%0t: out_tag expected %h, actual %h", $time,
						exp_r.out_tag, rsp_ch.out_tag);
					mismatches++;
				end
				if (rsp_ch.count !== exp_r.count) begin
					$display("%0t: count expected %0d, actual %0d", $time,
						exp_r.count, rsp_ch.count);
					mismatches++;
				end
				if (rsp_ch.is_empty !== exp_r.is_empty) begin
					$display("%0t: is_empty expected %b, actual %b", $time,
						exp_r.is_empty, rsp_ch.is_empty);
					mismatches++;
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			moved = 1'b1;
			pending_results.push_back(queue_model_apply(req_ch.op, req_ch.key, req_ch.tag));
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// response back-pressure
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= no_stall ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// leaves valid high on return; the caller sends again or lowers it in the same step
	task automatic send_item(logic op, key_t key, tag_t tag);
		if (!no_stall) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.key   <= key;
		req_ch.tag   <= tag;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// lowers valid and lets the checker log the last transaction before waiting for all pending responses
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_sort_mode(bit mode);
		wait_drained();
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we       <= 1'b0;
		model_sorted  = mode;
	endtask

	function automatic key_t pick_key(int style);
		case (style)
			0:       return key_t'($urandom);
			1:       return key_t'($urandom_range(0, 7));
			2: begin
				case ($urandom_range(0, 3))
					0:       return 32'h0000_0000;
					1:       return 32'hFFFF_FFFF;
					2:       return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			default: return 32'hFFFF_FFF8 + key_t'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic test_sorted_directed();
		send_item(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_INSERT, 32'h8000_0000, 16'h1234);
		send_item(OP_INSERT, 32'h0000_0000, 16'hFFFF);
		send_item(OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
		send_item(OP_INSERT, 32'h0000_0005, 16'h0001);
		send_item(OP_INSERT, 32'h0000_0005, 16'h0002);
		send_item(OP_INSERT, 32'hFFFF_FFFF, 16'h0003);
		send_item(OP_INSERT, 32'h0000_0000, 16'h0004);
		repeat (8) send_item(OP_REMOVE, 32'h0, 16'h0);
	endtask

	task automatic test_fifo_directed();
		send_item(OP_INSERT, 32'hFFFF_FFFF, 16'hAAAA);
		send_item(OP_INSERT, 32'h0000_0005, 16'h5555);
		send_item(OP_INSERT, 32'h0000_0000, 16'hFFFF);
		repeat (4) send_item(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
	endtask

	task automatic test_full_queue();
		int style;
		style = $urandom_range(0, 3);
		repeat (DEPTH + 1) send_item(OP_REMOVE, key_t'($urandom), tag_t'($urandom));
		repeat (DEPTH + 2) send_item(OP_INSERT, pick_key(style), tag_t'($urandom));
		repeat (DEPTH + 2) send_item(OP_REMOVE, key_t'($urandom), tag_t'($urandom));
	endtask

	task automatic test_random_traffic(int n_items, bit calm);
		int sent;
		int burst;
		int ins_pct;
		int style;
		sent     = 0;
		no_stall = calm;
		while (sent < n_items) begin
			burst = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0:       ins_pct = 25;
				1:       ins_pct = 50;
				default: ins_pct = 75;
			endcase
			style = $urandom_range(0, 3);
			repeat (burst) begin
				send_item(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE,
					pick_key(style), tag_t'($urandom));
				sent++;
			end
		end
		no_stall = 1'b0;
	endtask

	task automatic test_pause_and_drain();
		repeat (12) send_item(OP_INSERT, pick_key(0), tag_t'($urandom));
		wait_drained();
		repeat (14) send_item(OP_REMOVE, key_t'($urandom), tag_t'($urandom));
		wait_drained();
		repeat (6) send_item(OP_INSERT, pick_key(1), tag_t'($urandom));
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op    <= OP_INSERT;
		req_ch.key   <= '0;
		req_ch.tag   <= '0;
		mismatches   = 0;
		idle_cycles  = 0;
		no_stall     = 1'b0;
		model_fill   = 0;
		model_sorted = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_sort_mode(1'b1);
		test_sorted_directed();
		set_sort_mode(1'b0);
		test_fifo_directed();
		test_full_queue();
		test_random_traffic(500, 1'b0);
		set_sort_mode(1'b1);
		test_full_queue();
		test_random_traffic(600, 1'b0);
		test_random_traffic(300, 1'b1);
		test_pause_and_drain();
		set_sort_mode(1'b0);
		test_random_traffic(300, 1'b0);
		set_sort_mode(1'b1);
		test_random_traffic(200, 1'b0);

		wait_drained();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

### files.f
design/siq_pkg.sv
design/siq_if.sv
design/siq_cell.sv
design/sorted_insert_priority_queue.sv
tb/sv/tb.sv
